// ===== src/linked_free_list_pool_allocator_defines.svh =====
// Assertion macros shared by the checker of the pool allocator.
`ifndef LINKED_FREE_LIST_POOL_ALLOCATOR_DEFINES_SVH
`define LINKED_FREE_LIST_POOL_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFLPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFLPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lflpa_pkg.sv =====
`default_nettype none

package lflpa_pkg;

   localparam int POOL_ENTRIES = 32;
   localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int INDEX_FIELD_W = 5;
   localparam int STATUS_W = 2;
   localparam int CMP_W = (LINK_W > INDEX_FIELD_W) ? LINK_W : INDEX_FIELD_W;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

   typedef struct packed {
      logic op;
      logic [INDEX_FIELD_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_FIELD_W-1:0] result_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_UPD,
      ST_FREE_HEAD,
      ST_FREE_WALK,
      ST_FREE_UNLINK,
      ST_FREE_LINK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_FREE_HEAD,
      RD_USED_HEAD,
      RD_TARGET,
      RD_CUR
   } rd_sel_type;

   typedef struct packed {
      logic cap_req;
      logic rd_en;
      rd_sel_type rd_sel;
      logic alloc_commit;
      logic head_commit;
      logic walk_start;
      logic walk_step;
      logic unlink_commit;
      logic free_commit;
      logic res_load;
      logic [STATUS_W-1:0] res_status;
      logic rsp_push;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic free_empty;
      logic target_valid;
      logic head_hit;
      logic head_null;
      logic walk_end;
      logic walk_hit;
      logic rsp_slot_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/lflpa_ctrl.sv =====
`default_nettype none

module lflpa_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire lflpa_pkg::stat_type stat,
   output lflpa_pkg::cmd_type cmd
);

   lflpa_pkg::state_type state_ff;
   lflpa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lflpa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lflpa_pkg::ST_IDLE: begin
            if (req_valid && !reset) begin
               state_in = lflpa_pkg::ST_DISPATCH;
            end
         end
         lflpa_pkg::ST_DISPATCH: begin
            if (stat.op == lflpa_pkg::OP_ALLOC) begin
               if (stat.free_empty) begin
                  state_in = lflpa_pkg::ST_RESP;
               end else begin
                  state_in = lflpa_pkg::ST_ALLOC_UPD;
               end
            end else if (!stat.target_valid) begin
               state_in = lflpa_pkg::ST_RESP;
            end else if (stat.head_hit) begin
               state_in = lflpa_pkg::ST_FREE_HEAD;
            end else if (stat.head_null) begin
               state_in = lflpa_pkg::ST_RESP;
            end else begin
               state_in = lflpa_pkg::ST_FREE_WALK;
            end
         end
         lflpa_pkg::ST_ALLOC_UPD: begin
            state_in = lflpa_pkg::ST_RESP;
         end
         lflpa_pkg::ST_FREE_HEAD: begin
            state_in = lflpa_pkg::ST_FREE_LINK;
         end
         lflpa_pkg::ST_FREE_WALK: begin
            if (stat.walk_end) begin
               state_in = lflpa_pkg::ST_RESP;
            end else if (stat.walk_hit) begin
               state_in = lflpa_pkg::ST_FREE_UNLINK;
            end
         end
         lflpa_pkg::ST_FREE_UNLINK: begin
            state_in = lflpa_pkg::ST_FREE_LINK;
         end
         lflpa_pkg::ST_FREE_LINK: begin
            state_in = lflpa_pkg::ST_RESP;
         end
         lflpa_pkg::ST_RESP: begin
            if (stat.rsp_slot_free) begin
               state_in = lflpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lflpa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         lflpa_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.cap_req = req_valid && !reset;
         end
         lflpa_pkg::ST_DISPATCH: begin
            if (stat.op == lflpa_pkg::OP_ALLOC) begin
               if (stat.free_empty) begin
                  cmd.res_load = 1'b1;
                  cmd.res_status = lflpa_pkg::STATUS_EMPTY;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_sel = lflpa_pkg::RD_FREE_HEAD;
               end
            end else if (!stat.target_valid) begin
               cmd.res_load = 1'b1;
               cmd.res_status = lflpa_pkg::STATUS_NOT_USED;
            end else if (stat.head_hit) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = lflpa_pkg::RD_TARGET;
            end else if (stat.head_null) begin
               cmd.res_load = 1'b1;
               cmd.res_status = lflpa_pkg::STATUS_NOT_USED;
            end else begin
               cmd.walk_start = 1'b1;
               cmd.rd_en = 1'b1;
               cmd.rd_sel = lflpa_pkg::RD_USED_HEAD;
            end
         end
         lflpa_pkg::ST_ALLOC_UPD: begin
            cmd.alloc_commit = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_status = lflpa_pkg::STATUS_OK;
         end
         lflpa_pkg::ST_FREE_HEAD: begin
            cmd.head_commit = 1'b1;
         end
         lflpa_pkg::ST_FREE_WALK: begin
            if (stat.walk_end) begin
               cmd.res_load = 1'b1;
               cmd.res_status = lflpa_pkg::STATUS_NOT_USED;
            end else begin
               // The current entry is read either way: on a hit its link is what gets spliced.
               cmd.rd_en = 1'b1;
               cmd.rd_sel = lflpa_pkg::RD_CUR;
               cmd.walk_step = !stat.walk_hit;
            end
         end
         lflpa_pkg::ST_FREE_UNLINK: begin
            cmd.unlink_commit = 1'b1;
         end
         lflpa_pkg::ST_FREE_LINK: begin
            cmd.free_commit = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_status = lflpa_pkg::STATUS_OK;
         end
         lflpa_pkg::ST_RESP: begin
            cmd.rsp_push = stat.rsp_slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/lflpa_dp.sv =====
`default_nettype none

module lflpa_dp (
   input wire logic clock,
   input wire logic reset,
   input wire lflpa_pkg::req_type req_payload,
   input wire lflpa_pkg::cmd_type cmd,
   output lflpa_pkg::stat_type stat,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output lflpa_pkg::rsp_type rsp_payload
);

   localparam int LW = lflpa_pkg::LINK_W;
   localparam int IW = lflpa_pkg::IDX_W;
   localparam int FW = lflpa_pkg::INDEX_FIELD_W;
   localparam int CW = lflpa_pkg::CMP_W;

   // Next-link table. Entries never written read as their reset link, index plus one.
   logic [LW-1:0] link_mem [lflpa_pkg::POOL_ENTRIES];
   logic [lflpa_pkg::POOL_ENTRIES-1:0] written_ff;

   logic op_ff;
   logic [FW-1:0] target_ff;
   logic [LW-1:0] used_head_ff;
   logic [LW-1:0] used_head_in;
   logic [LW-1:0] free_head_ff;
   logic [LW-1:0] free_head_in;
   logic [LW-1:0] prev_ff;
   logic [LW-1:0] steps_ff;
   logic [LW-1:0] rd_q_ff;
   logic rd_written_ff;
   logic [IW-1:0] rd_addr_ff;
   logic [lflpa_pkg::STATUS_W-1:0] res_status_ff;
   logic [FW-1:0] res_index_ff;
   logic [FW-1:0] res_index_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   lflpa_pkg::rsp_type rsp_payload_ff;

   logic [LW-1:0] target_link;
   logic [LW-1:0] rd_link;
   logic [IW-1:0] rd_addr;
   logic wr_en;
   logic [IW-1:0] wr_addr;
   logic [LW-1:0] wr_data;

   assign target_link = LW'(target_ff);
   assign rd_link = rd_written_ff ? rd_q_ff : (LW'(rd_addr_ff) + LW'(1));

   always_comb begin
      case (cmd.rd_sel)
         lflpa_pkg::RD_FREE_HEAD: rd_addr = free_head_ff[IW-1:0];
         lflpa_pkg::RD_USED_HEAD: rd_addr = used_head_ff[IW-1:0];
         lflpa_pkg::RD_TARGET: rd_addr = target_link[IW-1:0];
         lflpa_pkg::RD_CUR: rd_addr = rd_link[IW-1:0];
         default: rd_addr = rd_link[IW-1:0];
      endcase
   end

   always_comb begin
      wr_en = cmd.alloc_commit || cmd.unlink_commit || cmd.free_commit;
      wr_addr = target_link[IW-1:0];
      wr_data = free_head_ff;
      if (cmd.alloc_commit) begin
         wr_addr = free_head_ff[IW-1:0];
         wr_data = used_head_ff;
      end else if (cmd.unlink_commit) begin
         wr_addr = prev_ff[IW-1:0];
         wr_data = rd_link;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= link_mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      used_head_in = used_head_ff;
      free_head_in = free_head_ff;
      if (cmd.alloc_commit) begin
         free_head_in = rd_link;
         used_head_in = free_head_ff;
      end
      if (cmd.head_commit) begin
         used_head_in = rd_link;
      end
      if (cmd.free_commit) begin
         free_head_in = target_link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_head_ff <= lflpa_pkg::NULL_LINK;
         free_head_ff <= '0;
      end else begin
         used_head_ff <= used_head_in;
         free_head_ff <= free_head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         op_ff <= req_payload.op;
         target_ff <= req_payload.entry_index;
      end
      if (cmd.walk_start) begin
         prev_ff <= used_head_ff;
         steps_ff <= LW'(1);
      end else if (cmd.walk_step) begin
         prev_ff <= rd_link;
         steps_ff <= steps_ff + LW'(1);
      end
   end

   always_comb begin
      res_index_in = '0;
      if (cmd.res_status == lflpa_pkg::STATUS_OK) begin
         if (op_ff == lflpa_pkg::OP_FREE) begin
            res_index_in = target_ff;
         end else begin
            res_index_in = FW'(free_head_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_index_ff <= res_index_in;
      end
      if (cmd.rsp_push) begin
         rsp_payload_ff.status <= res_status_ff;
         rsp_payload_ff.result_index <= res_index_ff;
      end
   end

   assign rsp_valid_in = cmd.rsp_push || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      stat.op = op_ff;
      stat.free_empty = !(free_head_ff < lflpa_pkg::NULL_LINK);
      stat.target_valid = CW'(target_ff) < CW'(lflpa_pkg::POOL_ENTRIES);
      stat.head_hit = used_head_ff == target_link;
      stat.head_null = !(used_head_ff < lflpa_pkg::NULL_LINK);
      stat.walk_end = !(rd_link < lflpa_pkg::NULL_LINK) || (steps_ff == lflpa_pkg::NULL_LINK);
      stat.walk_hit = rd_link == target_link;
      stat.rsp_slot_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ===== src/linked_free_list_pool_allocator.sv =====
// Fixed pool allocator over POOL_ENTRIES entries, kept as a free list and an in-use list
// that share one next-link table held in a single-port memory. An allocate item takes
// the head of the free list and returns its index; a free item walks the in-use list one
// link per cycle through that memory port. One item is in work at a time; a new item is
// taken while the previous result waits in the output register. Status 1 means the pool
// was empty, status 2 that the named entry was not in use; in both cases nothing changes
// and the index reads zero.
`default_nettype none

module linked_free_list_pool_allocator (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire lflpa_pkg::req_type req_payload,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output lflpa_pkg::rsp_type rsp_payload
);

   lflpa_pkg::cmd_type cmd;
   lflpa_pkg::stat_type stat;

   lflpa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat(stat),
      .cmd(cmd)
   );

   lflpa_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .cmd(cmd),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/lflpa_checker.sv =====
`default_nettype none

`include "linked_free_list_pool_allocator_defines.svh"

module lflpa_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire lflpa_pkg::rsp_type rsp_payload
);

   `LFLPA_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, (rsp_payload.status == lflpa_pkg::STATUS_OK) || (rsp_payload.status == lflpa_pkg::STATUS_EMPTY) || (rsp_payload.status == lflpa_pkg::STATUS_NOT_USED), "result item carries an undefined status")

   `LFLPA_ASSERT_SAME(a_fail_zero_index, clock, reset, rsp_valid && (rsp_payload.status != lflpa_pkg::STATUS_OK), rsp_payload.result_index == '0, "failed result item has a nonzero index")

   `LFLPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "allocator took a second item while one was in work")

   `LFLPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result item changed or vanished")

endmodule

bind linked_free_list_pool_allocator lflpa_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);

`default_nettype wire
